>>> hdl/page_framebuffer_line_circle_drawer_assert.svh
// Assertion macros used by the checker file pfd_checker.sv
`ifndef PAGE_FRAMEBUFFER_LINE_CIRCLE_DRAWER_ASSERT_SVH
`define PAGE_FRAMEBUFFER_LINE_CIRCLE_DRAWER_ASSERT_SVH
// implication checked at every clock edge outside reset
`define PFD_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);
// implication whose consequent is checked in the next cycle
`define PFD_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);
`endif

>>> hdl/pfd_pkg.sv
package pfd_pkg;
    typedef enum logic [2:0] {
        FUNC_DOT    = 3'd0,
        FUNC_LINE   = 3'd1,
        FUNC_RECT   = 3'd2,
        FUNC_CIRCLE = 3'd3,
        FUNC_CLEAR  = 3'd4,
        FUNC_READ   = 3'd5,
        FUNC_RSVD6  = 3'd6,
        FUNC_RSVD7  = 3'd7
    } func_t;

    // one decoded command as it travels from front to back
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] x_start;
        logic [7:0] y_start;
        logic [7:0] x_end;
        logic [7:0] y_end;
        logic [7:0] center_x;
        logic [7:0] center_y;
        logic [7:0] radius;
        logic [2:0] read_page;
        logic [6:0] read_column;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_RESET_CLEAR,
        ST_IDLE,
        ST_CLEAR,
        ST_SEG_INIT,
        ST_SEG_RUN,
        ST_RING_INIT,
        ST_RING_RUN,
        ST_PIX_RD,
        ST_PIX_WAIT,
        ST_PIX_WR,
        ST_READ_WAIT,
        ST_READ_DONE,
        ST_DONE
    } state_t;

    // queue status handed between the front queue and the engine
    typedef struct packed {
        logic valid;
        logic take;
    } qctl_t;
endpackage

>>> hdl/pfd_ram.sv
module pfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/pfd_front.sv
module pfd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  pfd_pkg::cmd_t cmd_in,
    output pfd_pkg::cmd_t cmd_out,
    output logic          cmd_valid,
    input  logic          cmd_take
);
    import pfd_pkg::*;

    // two-entry command queue
    cmd_t       slot_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd_out   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    // hold payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

>>> hdl/pfd_engine.sv
module pfd_engine #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  pfd_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_take,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    read_data
);
    import pfd_pkg::*;

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLUMNS);
    localparam int ROWS  = PAGES * 8;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    cmd_t   cmd_reg, cmd_next;

    // segment walker
    logic signed [10:0] px_reg, px_next, py_reg, py_next;
    logic signed [10:0] sx_reg, sx_next, sy_reg, sy_next;
    logic        [9:0]  dx_reg, dx_next, dy_reg, dy_next, span_reg, span_next;
    logic        [9:0]  ex_reg, ex_next, ey_reg, ey_next, n_reg, n_next;
    logic        [1:0]  side_reg, side_next;
    // ring walker
    logic signed [10:0] a_reg, a_next, b_reg, b_next;
    logic signed [12:0] d_reg, d_next;
    logic        [2:0]  oct_reg, oct_next;
    // pixel under update
    logic signed [10:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [AW:0] clr_reg, clr_next;
    logic [7:0]  out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    pfd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign empty     = !out_valid_reg;
    assign read_data = out_reg;

    logic signed [10:0] xa, ya, xb, yb, sdx, sdy;
    logic signed [10:0] ox, oy;
    logic               on_frame;
    logic [AW-1:0]      pix_addr;
    logic [AW-1:0]      byte_addr;
    logic [9:0]         ex_s, ey_s;

    // pick the endpoints of the current rectangle side or line
    always_comb
    begin
        xa = {3'b0, cmd_reg.x_start};
        ya = {3'b0, cmd_reg.y_start};
        xb = {3'b0, cmd_reg.x_end};
        yb = {3'b0, cmd_reg.y_end};
        if (cmd_reg.func == FUNC_RECT)
        begin
            case (side_reg)
                2'd0: yb = {3'b0, cmd_reg.y_start};
                2'd1: xb = {3'b0, cmd_reg.x_start};
                2'd2: ya = {3'b0, cmd_reg.y_end};
                default: xa = {3'b0, cmd_reg.x_end};
            endcase
        end
        sdx = xb - xa;
        sdy = yb - ya;
    end

    // eight symmetric points of the ring
    always_comb
    begin
        case (oct_reg)
            3'd0: begin ox =  a_reg; oy = -b_reg; end
            3'd1: begin ox =  b_reg; oy = -a_reg; end
            3'd2: begin ox =  b_reg; oy =  a_reg; end
            3'd3: begin ox =  a_reg; oy =  b_reg; end
            3'd4: begin ox = -a_reg; oy =  b_reg; end
            3'd5: begin ox = -b_reg; oy =  a_reg; end
            3'd6: begin ox = -a_reg; oy = -b_reg; end
            default: begin ox = -b_reg; oy = -a_reg; end
        endcase
    end

    assign on_frame = (tx_reg >= 0) && (tx_reg < 11'(COLUMNS))
                   && (ty_reg >= 0) && (ty_reg < 11'(ROWS));
    assign pix_addr = AW'(({21'b0, ty_reg[10:3]} * COLUMNS) + {21'b0, tx_reg[CW-1:0]});
    assign byte_addr = AW'(({24'b0, cmd_reg.read_page} * COLUMNS)
                     + {25'b0, cmd_reg.read_column});
    assign ex_s = ex_reg + dx_reg;
    assign ey_s = ey_reg + dy_reg;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cmd_next       = cmd_reg;
        px_next = px_reg; py_next = py_reg; sx_next = sx_reg; sy_next = sy_reg;
        dx_next = dx_reg; dy_next = dy_reg; span_next = span_reg;
        ex_next = ex_reg; ey_next = ey_reg; n_next = n_reg; side_next = side_reg;
        a_next = a_reg; b_next = b_reg; d_next = d_reg; oct_next = oct_reg;
        tx_next = tx_reg; ty_next = ty_reg;
        clr_next       = clr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cmd_take       = 1'b0;
        we             = 1'b0;
        waddr          = pix_addr;
        wdata          = rdata | (8'd1 << ty_reg[2:0]);
        raddr          = pix_addr;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // sweep the store one byte a cycle
            ST_RESET_CLEAR, ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = 8'd0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(DEPTH - 1))
                begin
                    state_next = (state_reg == ST_CLEAR) ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take  = 1'b1;
                    cmd_next  = cmd;
                    side_next = 2'd0;
                    clr_next  = '0;
                    case (cmd.func)
                        FUNC_DOT:
                        begin
                            tx_next = {3'b0, cmd.x_start};
                            ty_next = {3'b0, cmd.y_start};
                            ret_next = ST_DONE;
                            state_next = ST_PIX_RD;
                        end
                        FUNC_LINE, FUNC_RECT: state_next = ST_SEG_INIT;
                        FUNC_CIRCLE: state_next = ST_RING_INIT;
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        FUNC_READ: state_next = ST_READ_WAIT;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SEG_INIT:
            begin
                px_next = xa;
                py_next = ya;
                sx_next = (sdx > 0) ? 11'sd1 : ((sdx == 0) ? 11'sd0 : -11'sd1);
                sy_next = (sdy > 0) ? 11'sd1 : ((sdy == 0) ? 11'sd0 : -11'sd1);
                dx_next = sdx[10] ? 10'(-sdx) : sdx[9:0];
                dy_next = sdy[10] ? 10'(-sdy) : sdy[9:0];
                span_next = (dx_next > dy_next) ? dx_next : dy_next;
                ex_next = '0;
                ey_next = '0;
                n_next  = '0;
                state_next = ST_SEG_RUN;
            end
            ST_SEG_RUN:
            begin
                if (n_reg > span_reg + 10'd1)
                begin
                    if (cmd_reg.func == FUNC_RECT && side_reg != 2'd3)
                    begin
                        side_next  = side_reg + 2'd1;
                        state_next = ST_SEG_INIT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    tx_next = px_reg;
                    ty_next = py_reg;
                    n_next  = n_reg + 10'd1;
                    ex_next = ex_s;
                    ey_next = ey_s;
                    if (ex_s > span_reg)
                    begin
                        ex_next = ex_s - span_reg;
                        px_next = px_reg + sx_reg;
                    end
                    if (ey_s > span_reg)
                    begin
                        ey_next = ey_s - span_reg;
                        py_next = py_reg + sy_reg;
                    end
                    ret_next   = ST_SEG_RUN;
                    state_next = ST_PIX_RD;
                end
            end
            ST_RING_INIT:
            begin
                a_next   = '0;
                b_next   = {3'b0, cmd_reg.radius};
                d_next   = 13'sd3 - {4'b0, cmd_reg.radius, 1'b0};
                oct_next = 3'd0;
                state_next = ST_RING_RUN;
            end
            ST_RING_RUN:
            begin
                if (a_reg > b_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    tx_next  = {3'b0, cmd_reg.center_x} + ox;
                    ty_next  = {3'b0, cmd_reg.center_y} + oy;
                    oct_next = oct_reg + 3'd1;
                    if (oct_reg == 3'd7)
                    begin
                        a_next = a_reg + 11'sd1;
                        if (d_reg < 0)
                        begin
                            d_next = d_reg + 13'(4 * (a_reg + 11'sd1)) + 13'sd6;
                        end
                        else
                        begin
                            d_next = d_reg + 13'sd10
                                   + 13'(4 * (a_reg + 11'sd1 - b_reg));
                            b_next = b_reg - 11'sd1;
                        end
                    end
                    ret_next   = ST_RING_RUN;
                    state_next = ST_PIX_RD;
                end
            end
            // read-modify-write of one pixel
            ST_PIX_RD:
            begin
                state_next = on_frame ? ST_PIX_WAIT : ret_reg;
            end
            ST_PIX_WAIT:
            begin
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR:
            begin
                we = 1'b1;
                state_next = ret_reg;
            end
            ST_READ_WAIT:
            begin
                raddr = byte_addr;
                state_next = ST_READ_DONE;
            end
            // hold the read address so the byte survives a stalled output
            ST_READ_DONE:
            begin
                raddr = byte_addr;
                if (!out_valid_next)
                begin
                    out_valid_next = 1'b1;
                    out_next = ({29'b0, cmd_reg.read_page} < PAGES
                             && {25'b0, cmd_reg.read_column} < COLUMNS) ? rdata : 8'd0;
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_next)
                begin
                    out_valid_next = 1'b1;
                    out_next   = 8'd0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ret_reg <= ret_next; cmd_reg <= cmd_next;
        px_reg <= px_next; py_reg <= py_next; sx_reg <= sx_next; sy_reg <= sy_next;
        dx_reg <= dx_next; dy_reg <= dy_next; span_reg <= span_next;
        ex_reg <= ex_next; ey_reg <= ey_next; n_reg <= n_next; side_reg <= side_next;
        a_reg <= a_next; b_reg <= b_next; d_reg <= d_next; oct_reg <= oct_next;
        tx_reg <= tx_next; ty_reg <= ty_next; out_reg <= out_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RESET_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

>>> hdl/page_framebuffer_line_circle_drawer.sv
// Frame store of PAGES x COLUMNS bytes with dot, line, rectangle, circle, clear and
// byte-read commands; each command yields one read_data beat (zero unless a read).
// Commands queue two deep in front of a drawing engine. Each pixel takes one step of the
// walker and, if it lies on the frame, a read-modify-write (read, wait, write) on the
// single frame RAM. After reset a clearing pass over all PAGES*COLUMNS bytes runs
// before the first command is taken.
module page_framebuffer_line_circle_drawer #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] func,
    input  logic [7:0] x_start,
    input  logic [7:0] y_start,
    input  logic [7:0] x_end,
    input  logic [7:0] y_end,
    input  logic [7:0] center_x,
    input  logic [7:0] center_y,
    input  logic [7:0] radius,
    input  logic [2:0] read_page,
    input  logic [6:0] read_column,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] read_data
);
    import pfd_pkg::*;

    cmd_t  cmd_in, cmd_q;
    qctl_t qctl;

    assign cmd_in = '{func: func, x_start: x_start, y_start: y_start, x_end: x_end,
                      y_end: y_end, center_x: center_x, center_y: center_y,
                      radius: radius, read_page: read_page, read_column: read_column};

    pfd_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd_in(cmd_in),
        .cmd_out(cmd_q), .cmd_valid(qctl.valid), .cmd_take(qctl.take)
    );

    pfd_engine #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_engine (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_q), .cmd_valid(qctl.valid),
        .cmd_take(qctl.take), .empty(empty), .pop(pop), .read_data(read_data)
    );
endmodule

>>> hdl/pfd_checker.sv
`include "page_framebuffer_line_circle_drawer_assert.svh"
module pfd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] read_data
);
    // a waiting result beat holds until it is taken
    `PFD_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(read_data), "result beat dropped or changed while waiting")
    // the input queue only fills on a push
    `PFD_ASSERT_NEXT(a_full_needs_push, clk, rst_n, !full && !push, !full, "queue filled without a push")
    // handshake status is always known outside reset
    `PFD_ASSERT_IMP(a_no_x_full, clk, rst_n, 1'b1, !$isunknown(full) && !$isunknown(empty), "handshake status unknown")
endmodule

bind page_framebuffer_line_circle_drawer pfd_checker u_pfd_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .empty(empty), .pop(pop), .read_data(read_data)
);

>>> dv/page_framebuffer_line_circle_drawer_tb.sv
module page_framebuffer_line_circle_drawer_tb;
    import pfd_pkg::*;

    localparam int COLS = 128;
    localparam int PGS  = 8;
    localparam int ROWS = PGS * 8;
    localparam longint CYCLE_LIMIT = 64'd20_000_000;

    // predicted frame store and pending read bytes
    class frame_scoreboard;
        logic [7:0] frame_mem [PGS*COLS];
        logic [7:0] pending_bytes [$];
        int         errors;

        function void wipe();
            foreach (frame_mem[i]) frame_mem[i] = 8'h00;
        endfunction

        function void plot(int x, int y);
            if (x < 0 || x >= COLS || y < 0 || y >= ROWS) return;
            frame_mem[(y >> 3) * COLS + x] |= 8'(1 << (y & 7));
        endfunction

        function void trace_segment(int xa, int ya, int xb, int yb);
            int dx, dy, sx, sy, span, ex, ey, px, py;
            dx = xb - xa;
            dy = yb - ya;
            sx = (dx > 0) ? 1 : ((dx == 0) ? 0 : -1);
            sy = (dy > 0) ? 1 : ((dy == 0) ? 0 : -1);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            span = (dx > dy) ? dx : dy;
            ex = 0; ey = 0; px = xa; py = ya;
            for (int n = 0; n <= span + 1; n++)
            begin
                plot(px, py);
                ex += dx;
                ey += dy;
                if (ex > span)
                begin
                    ex -= span;
                    px += sx;
                end
                if (ey > span)
                begin
                    ey -= span;
                    py += sy;
                end
            end
        endfunction

        function void trace_ring(int cx, int cy, int r);
            int a, b, d;
            a = 0; b = r; d = 3 - (r << 1);
            while (a <= b)
            begin
                plot(cx + a, cy - b); plot(cx + b, cy - a);
                plot(cx + b, cy + a); plot(cx + a, cy + b);
                plot(cx - a, cy + b); plot(cx - b, cy + a);
                plot(cx - a, cy - b); plot(cx - b, cy - a);
                a++;
                if (d < 0) d += 4 * a + 6;
                else
                begin
                    d += 10 + 4 * (a - b);
                    b--;
                end
            end
        endfunction

        // apply one accepted command and queue its expected byte
        function void note_command(cmd_t c);
            logic [7:0] rd;
            rd = 8'h00;
            case (c.func)
                FUNC_DOT:    plot(c.x_start, c.y_start);
                FUNC_LINE:   trace_segment(c.x_start, c.y_start, c.x_end, c.y_end);
                FUNC_RECT:
                begin
                    trace_segment(c.x_start, c.y_start, c.x_end, c.y_start);
                    trace_segment(c.x_start, c.y_start, c.x_start, c.y_end);
                    trace_segment(c.x_start, c.y_end, c.x_end, c.y_end);
                    trace_segment(c.x_end, c.y_start, c.x_end, c.y_end);
                end
                FUNC_CIRCLE: trace_ring(c.center_x, c.center_y, c.radius);
                FUNC_CLEAR:  wipe();
                FUNC_READ:   rd = frame_mem[c.read_page * COLS + c.read_column];
                default:     ;
            endcase
            pending_bytes.push_back(rd);
        endfunction

        function void check_byte(logic [7:0] got);
            logic [7:0] want;
            if (pending_bytes.size() == 0)
            begin
                $error("read_data beat with nothing pending: actual %h", got);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (got !== want)
            begin
                $error("read_data expected %h actual %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [2:0] func;
    logic [7:0] x_start, y_start, x_end, y_end;
    logic [7:0] center_x, center_y, radius;
    logic [2:0] read_page;
    logic [6:0] read_column;
    logic       empty;
    logic       pop;
    logic [7:0] read_data;

    frame_scoreboard sb;
    bit     calm;
    longint cycle_count;

    page_framebuffer_line_circle_drawer uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
        .center_x(center_x), .center_y(center_y), .radius(radius),
        .read_page(read_page), .read_column(read_column),
        .empty(empty), .pop(pop), .read_data(read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("page_framebuffer_line_circle_drawer_tb NOT OK");
                $finish;
            end
        end
    end

    // send one command beat, with random idle cycles in front unless calm
    task automatic send_command(cmd_t c);
        while (!calm && $urandom_range(99) < 6)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        func        <= c.func;
        x_start     <= c.x_start;
        y_start     <= c.y_start;
        x_end       <= c.x_end;
        y_end       <= c.y_end;
        center_x    <= c.center_x;
        center_y    <= c.center_y;
        radius      <= c.radius;
        read_page   <= c.read_page;
        read_column <= c.read_column;
        do @(posedge clk); while (full);
        sb.note_command(c);
    endtask

    function automatic cmd_t random_command();
        cmd_t c;
        int   pick;
        c.x_start = 8'($urandom); c.y_start = 8'($urandom);
        c.x_end = 8'($urandom); c.y_end = 8'($urandom);
        c.center_x = 8'($urandom); c.center_y = 8'($urandom);
        c.read_page = 3'($urandom); c.read_column = 7'($urandom);
        // mostly on-frame coordinates, short radii
        if ($urandom_range(3) != 0)
        begin
            c.x_start = 8'($urandom_range(COLS - 1));
            c.y_start = 8'($urandom_range(ROWS - 1));
            c.x_end = 8'($urandom_range(COLS - 1));
            c.y_end = 8'($urandom_range(ROWS - 1));
            c.center_x = 8'($urandom_range(COLS - 1));
            c.center_y = 8'($urandom_range(ROWS - 1));
        end
        c.radius = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(40));
        pick = $urandom_range(99);
        if (pick < 20)      c.func = FUNC_DOT;
        else if (pick < 35) c.func = FUNC_LINE;
        else if (pick < 43) c.func = FUNC_RECT;
        else if (pick < 53) c.func = FUNC_CIRCLE;
        else if (pick < 55) c.func = FUNC_CLEAR;
        else if (pick < 97) c.func = FUNC_READ;
        else                c.func = ($urandom_range(1) == 0) ? FUNC_RSVD6 : FUNC_RSVD7;
        return c;
    endfunction

    function automatic cmd_t make_command(logic [2:0] f, int a, int b, int c2, int d);
        cmd_t c;
        c = '0;
        c.func = f;
        c.x_start = 8'(a); c.y_start = 8'(b); c.x_end = 8'(c2); c.y_end = 8'(d);
        c.center_x = 8'(a); c.center_y = 8'(b); c.radius = 8'(c2);
        c.read_page = 3'(d >> 7); c.read_column = 7'(d);
        return c;
    endfunction

    // result side: random stalls on pop
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty) sb.check_byte(read_data);
            pop <= calm ? 1'b1 : ($urandom_range(99) >= 6);
        end
    end

    initial
    begin
        cmd_t c;
        sb = new();
        sb.wipe();
        calm = 1'b0;
        rst_n = 1'b0;
        push <= 1'b0;
        func <= FUNC_DOT;
        {x_start, y_start, x_end, y_end} <= '0;
        {center_x, center_y, radius} <= '0;
        read_page <= '0;
        read_column <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners, off-frame, degenerate shapes, reads, unused codes, a clear
        send_command(make_command(FUNC_DOT, 0, 0, 0, 0));
        send_command(make_command(FUNC_DOT, 127, 63, 0, 0));
        send_command(make_command(FUNC_DOT, 128, 64, 0, 0));
        send_command(make_command(FUNC_DOT, 255, 255, 0, 0));
        send_command(make_command(FUNC_READ, 0, 0, 0, 0));
        send_command(make_command(FUNC_READ, 0, 0, 0, 7 * 128 + 127));
        send_command(make_command(FUNC_LINE, 10, 10, 10, 10));
        send_command(make_command(FUNC_LINE, 0, 0, 255, 255));
        send_command(make_command(FUNC_LINE, 120, 5, 3, 60));
        send_command(make_command(FUNC_RECT, 5, 5, 40, 30));
        send_command(make_command(FUNC_RECT, 250, 200, 100, 10));
        send_command(make_command(FUNC_CIRCLE, 64, 32, 0, 0));
        send_command(make_command(FUNC_CIRCLE, 64, 32, 20, 0));
        send_command(make_command(FUNC_CIRCLE, 0, 0, 255, 0));
        send_command(make_command(FUNC_CIRCLE, 255, 255, 200, 0));
        send_command(make_command(FUNC_READ, 0, 0, 0, 2 * 128 + 10));
        send_command(make_command(FUNC_READ, 0, 0, 0, 4 * 128 + 64));
        send_command(make_command(FUNC_RSVD6, 1, 2, 3, 4));
        send_command(make_command(FUNC_RSVD7, 255, 255, 255, 1023));
        send_command(make_command(FUNC_CLEAR, 0, 0, 0, 0));
        send_command(make_command(FUNC_READ, 0, 0, 0, 4 * 128 + 64));

        // random, with a stretch of back-to-back beats in the middle
        for (int i = 0; i < 400; i++)
        begin
            calm = (i >= 150 && i < 220);
            c = random_command();
            send_command(c);
        end
        calm = 1'b0;
        push <= 1'b0;

        // drain, then give the engine time to finish any trailing beat
        while (sb.pending_bytes.size() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        if (sb.errors == 0 && sb.pending_bytes.size() == 0)
            $display("page_framebuffer_line_circle_drawer_tb OK");
        else
            $display("page_framebuffer_line_circle_drawer_tb NOT OK");
        $finish;
    end
endmodule
